@@ hw/rtl/ftq_pkg.sv @@
package ftq_pkg;

  localparam int QueueDepthDef = 4;
  localparam int MaxPayloadDef = 32;
  localparam int BytesPerFrag = 6;
  localparam int MaxFragmentsDef = 8;

  localparam logic [15:0] TimeoutRst = 16'd100;
  localparam logic [3:0] MaxRetriesRst = 4'd3;
  localparam logic [7:0] AckOkRst = 8'd0;

  // Command codes.
  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdTick = 2'd1;
  localparam logic [1:0] CmdAck = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegRetries = 2'd1;
  localparam logic [1:0] RegAckOk = 2'd2;

  // Result event codes.
  localparam logic [2:0] EvFrag = 3'd0;
  localparam logic [2:0] EvEnq = 3'd1;
  localparam logic [2:0] EvRej = 3'd2;
  localparam logic [2:0] EvDeliv = 3'd3;
  localparam logic [2:0] EvFail = 3'd4;

  // One queued transaction between the front and back parts.
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] packet_type;
    logic [7:0] data_byte;
    logic last_byte;
    logic [7:0] ack_code;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] frame_type;
    logic [5:0] frame_total;
    logic [5:0] frame_index;
    logic [47:0] frame_payload;
    logic [3:0] retry_number;
    logic last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_READ, ST_EMIT1, ST_EMIT2
  } st_t;

  // Fragment count of a length: ceil(len / 6) for lengths up to 378.
  function automatic logic [5:0] frag_total(input logic [8:0] len);
    logic [19:0] prod;
    begin
      prod = ({11'd0, len} + 20'd5) * 20'd683;
      frag_total = prod[17:12];
    end
  endfunction

endpackage

@@ hw/rtl/ftq_front.sv @@
// Front part: a two-entry queue of incoming commands.
module ftq_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  ftq_pkg::cmd_t in_cmd,
  output logic q_valid,
  input  logic q_take,
  output ftq_pkg::cmd_t q_cmd
);

  ftq_pkg::cmd_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_take;
  assign q_cmd = mem_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_cmd;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/ftq_back.sv @@
// Back part: queue state, payload memory and result sequencing.
module ftq_back #(
  parameter int QUEUE_DEPTH = ftq_pkg::QueueDepthDef,
  parameter int MAX_PAYLOAD = ftq_pkg::MaxPayloadDef,
  parameter int MAX_FRAGMENTS = ftq_pkg::MaxFragmentsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_take,
  input  ftq_pkg::cmd_t q_cmd,
  input  logic [15:0] timeout,
  input  logic [3:0] max_retries,
  input  logic [7:0] ack_ok,
  output logic out_valid,
  input  logic out_stall,
  output ftq_pkg::res_t out_res
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW = $clog2(MAX_PAYLOAD + 2);
  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int StoreSize = QUEUE_DEPTH * MAX_PAYLOAD;
  localparam int AW = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LW-1:0] BadLoad = LW'(MAX_PAYLOAD + 1);

  logic [7:0] store_r [StoreSize];
  logic [3:0] slot_type_r [QUEUE_DEPTH];
  logic [8:0] slot_len_r [QUEUE_DEPTH];

  logic [QW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [LW-1:0] load_r;
  logic [5:0] fidx_r;
  logic [3:0] retry_r;
  logic wait_r;
  logic [15:0] elap_r;

  ftq_pkg::st_t st_r, st_nxt;
  ftq_pkg::cmd_t cmd_r;
  ftq_pkg::res_t r1_r, r2_r;
  logic two_r;
  logic [2:0] bi_r;
  logic [47:0] pay_r;
  logic [7:0] rd_r;
  logic rd_ok_r, rd_pend_r;

  logic full, obusy;
  logic [QW-1:0] head_inc, tail_inc;
  logic [8:0] hlen;
  logic [5:0] htotal;
  logic [8:0] boff;
  logic boff_ok;
  logic [AW-1:0] raddr, waddr;

  assign full = (count_r >= CW'(QUEUE_DEPTH));
  assign head_inc = (32'(head_r) == QUEUE_DEPTH - 1) ? '0 : head_r + QW'(1);
  assign tail_inc = (32'(tail_r) == QUEUE_DEPTH - 1) ? '0 : tail_r + QW'(1);
  assign hlen = slot_len_r[head_r];
  assign htotal = ftq_pkg::frag_total(hlen);
  assign boff = 9'(fidx_r) * 9'd6 + 9'(bi_r);
  assign boff_ok = (boff < hlen) && (boff < 9'(MAX_PAYLOAD));
  assign raddr = AW'(32'(head_r) * MAX_PAYLOAD + 32'(boff[PW-1:0]));
  assign waddr = AW'(32'(tail_r) * MAX_PAYLOAD + 32'(load_r[PW-1:0]));
  assign obusy = out_valid && out_stall;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ftq_pkg::ST_IDLE: if (q_valid) st_nxt = ftq_pkg::ST_DECIDE;
      ftq_pkg::ST_DECIDE: st_nxt = ftq_pkg::ST_READ;
      ftq_pkg::ST_READ:
        if (!rd_pend_r && bi_r == 3'd6) st_nxt = ftq_pkg::ST_EMIT1;
      ftq_pkg::ST_EMIT1: if (!obusy) st_nxt = ftq_pkg::ST_EMIT2;
      ftq_pkg::ST_EMIT2: if (!obusy) st_nxt = ftq_pkg::ST_IDLE;
      default: st_nxt = ftq_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_take = 1'b0;
    case (st_r)
      ftq_pkg::ST_IDLE: q_take = q_valid;
      default: q_take = 1'b0;
    endcase
  end

  // Payload memory port.
  always_ff @(posedge clk) begin
    if (st_r == ftq_pkg::ST_DECIDE && cmd_r.command == ftq_pkg::CmdLoad &&
        !(load_r >= LW'(MAX_PAYLOAD) || full)) begin
      store_r[waddr] <= cmd_r.data_byte;
    end
    rd_r <= store_r[raddr];
    rd_ok_r <= boff_ok;
  end

  // Control and queue state.
  always_ff @(posedge clk) begin
    ftq_pkg::res_t r1;
    logic [3:0] ev_type;
    logic [5:0] ev_tot;
    logic [8:0] len;
    logic [5:0] tot;
    logic pop_now, wt, frag_go, ov;
    logic [15:0] el;
    logic [5:0] nf;
    logic [3:0] nr;
    logic [LW-1:0] nl;
    if (!rst_n) begin
      st_r <= ftq_pkg::ST_IDLE;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      load_r <= '0;
      fidx_r <= '0;
      retry_r <= '0;
      wait_r <= 1'b0;
      elap_r <= '0;
      out_valid <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      // A result stays while stalled and drops once it is taken.
      ov = out_valid && out_stall;
      case (st_r)
        ftq_pkg::ST_IDLE: begin
          if (q_valid) cmd_r <= q_cmd;
        end
        ftq_pkg::ST_DECIDE: begin
          r1 = '0;
          frag_go = 1'b0;
          ev_type = slot_type_r[head_r];
          ev_tot = htotal;
          case (cmd_r.command)
            ftq_pkg::CmdLoad: begin
              if (load_r >= LW'(MAX_PAYLOAD) || full) begin
                nl = BadLoad;
              end else begin
                nl = load_r + LW'(1);
              end
              if (cmd_r.last_byte) begin
                len = 9'(nl);
                nl = '0;
                r1.frame_type = cmd_r.packet_type;
                r1.last = 1'b1;
                r1.event_res = ftq_pkg::EvRej;
                tot = ftq_pkg::frag_total(len);
                if (len > 9'(MAX_PAYLOAD) || len == 9'd0 || full) begin
                  r1.frame_total = '0;
                end else if (32'(tot) > MAX_FRAGMENTS) begin
                  r1.frame_total = tot;
                end else begin
                  r1.frame_total = tot;
                  r1.event_res = ftq_pkg::EvEnq;
                  slot_type_r[tail_r] <= cmd_r.packet_type;
                  slot_len_r[tail_r] <= len;
                  tail_r <= tail_inc;
                  count_r <= count_r + CW'(1);
                end
              end
              load_r <= nl;
            end
            ftq_pkg::CmdTick: begin
              if (count_r != '0) begin
                pop_now = 1'b0;
                wt = wait_r;
                el = elap_r;
                nf = fidx_r;
                nr = retry_r;
                if (wait_r) begin
                  if (el != 16'hFFFF) el = el + 16'd1;
                  if (el >= timeout) begin
                    if (retry_r < max_retries) begin
                      nr = retry_r + 4'd1;
                      nf = '0;
                      wt = 1'b0;
                      el = '0;
                    end else begin
                      pop_now = 1'b1;
                      r1.event_res = ftq_pkg::EvFail;
                      r1.frame_type = ev_type;
                      r1.frame_total = ev_tot;
                      r1.retry_number = retry_r;
                    end
                  end
                end
                if (pop_now) begin
                  head_r <= head_inc;
                  count_r <= count_r - CW'(1);
                  nf = '0;
                  nr = '0;
                  wt = 1'b0;
                  el = '0;
                  // A fragment of the next packet follows if one is queued.
                  frag_go = (count_r > CW'(1));
                  r1.last = !frag_go;
                end else begin
                  frag_go = !wt;
                end
                fidx_r <= nf;
                retry_r <= nr;
                wait_r <= wt;
                elap_r <= el;
              end
            end
            ftq_pkg::CmdAck: begin
              if (count_r != '0 && cmd_r.ack_code == ack_ok) begin
                r1.event_res = ftq_pkg::EvDeliv;
                r1.frame_type = ev_type;
                r1.frame_total = ev_tot;
                r1.retry_number = retry_r;
                r1.last = 1'b1;
                head_r <= head_inc;
                count_r <= count_r - CW'(1);
                fidx_r <= '0;
                retry_r <= '0;
                wait_r <= 1'b0;
                elap_r <= '0;
              end
            end
            default: ;
          endcase
          r1_r <= r1;
          r2_r <= '0;
          two_r <= frag_go;
          bi_r <= frag_go ? 3'd0 : 3'd6;
          rd_pend_r <= frag_go;
          pay_r <= '0;
        end
        ftq_pkg::ST_READ: begin
          // One payload byte per cycle from the store's read port.
          if (rd_pend_r) begin
            if (bi_r != 3'd0) begin
              pay_r <= {pay_r[39:0], rd_ok_r ? rd_r : 8'd0};
            end
            if (bi_r == 3'd6) begin
              rd_pend_r <= 1'b0;
              r2_r.event_res <= ftq_pkg::EvFrag;
              r2_r.frame_type <= slot_type_r[head_r];
              r2_r.frame_total <= htotal;
              r2_r.frame_index <= fidx_r;
              r2_r.frame_payload <= {pay_r[39:0], rd_ok_r ? rd_r : 8'd0};
              r2_r.retry_number <= retry_r;
              r2_r.last <= 1'b1;
              if (fidx_r + 6'd1 >= htotal) begin
                fidx_r <= '0;
                wait_r <= 1'b1;
                elap_r <= '0;
              end else begin
                fidx_r <= fidx_r + 6'd1;
              end
            end else begin
              bi_r <= bi_r + 3'd1;
            end
          end
        end
        ftq_pkg::ST_EMIT1: begin
          if (!obusy && (r1_r.last || (two_r && r1_r.event_res == ftq_pkg::EvFail))) begin
            out_res <= r1_r;
            ov = 1'b1;
          end
        end
        ftq_pkg::ST_EMIT2: begin
          if (!obusy && two_r && r2_r.last) begin
            out_res <= r2_r;
            ov = 1'b1;
          end
        end
        default: ;
      endcase
      out_valid <= ov;
    end
  end

endmodule

@@ hw/rtl/fragmenting_tx_queue_with_ack_retry_core.sv @@
// An accepted command waits in the front queue, is taken in ST_IDLE and decided in
// ST_DECIDE; a tick that sends a fragment reads its payload bytes in ST_READ. The
// results are registered out in ST_EMIT1 and ST_EMIT2, which hold while stalled.
// The back part takes a new command only after ST_EMIT2 returns it to ST_IDLE.
// A two-entry command queue in front lets input arrive while the back part works.
// Reset (rst_n low, synchronous) empties the queue and restores register defaults.
module fragmenting_tx_queue_with_ack_retry_core #(
  parameter int QUEUE_DEPTH = ftq_pkg::QueueDepthDef,
  parameter int MAX_PAYLOAD = ftq_pkg::MaxPayloadDef,
  parameter int MAX_FRAGMENTS = ftq_pkg::MaxFragmentsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_command,
  input  logic [3:0] in_packet_type,
  input  logic [7:0] in_data_byte,
  input  logic in_last_byte,
  input  logic [7:0] in_ack_code,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] out_event_res,
  output logic [3:0] out_frame_type,
  output logic [5:0] out_frame_total,
  output logic [5:0] out_frame_index,
  output logic [47:0] out_frame_payload,
  output logic [3:0] out_retry_number,
  output logic out_last
);

  logic [15:0] timeout_r;
  logic [3:0] retries_r;
  logic [7:0] ack_ok_r;
  ftq_pkg::cmd_t in_cmd, q_cmd;
  ftq_pkg::res_t res;
  logic q_valid, q_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ftq_pkg::TimeoutRst;
      retries_r <= ftq_pkg::MaxRetriesRst;
      ack_ok_r <= ftq_pkg::AckOkRst;
    end else if (cfg_we) begin
      case (cfg_index)
        ftq_pkg::RegTimeout: timeout_r <= cfg_data;
        ftq_pkg::RegRetries: retries_r <= cfg_data[3:0];
        ftq_pkg::RegAckOk: ack_ok_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{command: in_command, packet_type: in_packet_type,
                    data_byte: in_data_byte, last_byte: in_last_byte,
                    ack_code: in_ack_code};

  ftq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  ftq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .MAX_PAYLOAD(MAX_PAYLOAD),
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_cmd(q_cmd), .timeout(timeout_r), .max_retries(retries_r),
    .ack_ok(ack_ok_r), .out_valid(out_valid), .out_stall(out_stall),
    .out_res(res)
  );

  assign out_event_res = res.event_res;
  assign out_frame_type = res.frame_type;
  assign out_frame_total = res.frame_total;
  assign out_frame_index = res.frame_index;
  assign out_frame_payload = res.frame_payload;
  assign out_retry_number = res.retry_number;
  assign out_last = res.last;

endmodule

@@ bench/fragmenting_tx_queue_with_ack_retry_core_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts the results of every accepted command and
// compares each accepted result against the oldest prediction.
module fragmenting_tx_queue_with_ack_retry_core_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] in_command,
  input  logic [3:0] in_packet_type,
  input  logic [7:0] in_data_byte,
  input  logic in_last_byte,
  input  logic [7:0] in_ack_code,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [2:0] out_event_res,
  input  logic [3:0] out_frame_type,
  input  logic [5:0] out_frame_total,
  input  logic [5:0] out_frame_index,
  input  logic [47:0] out_frame_payload,
  input  logic [3:0] out_retry_number,
  input  logic out_last,
  output int fail_count,
  output int pending_results,
  output int results_seen
);

  localparam int Depth = ftq_pkg::QueueDepthDef;
  localparam int MaxLen = ftq_pkg::MaxPayloadDef;
  localparam int BadLoad = MaxLen + 1;

  // Predictor copy of the configuration and queue state.
  logic [15:0] timeout_ticks;
  logic [3:0] retry_limit;
  logic [7:0] ok_code;
  logic [7:0] store [Depth * MaxLen];
  logic [3:0] type_of [Depth];
  int len_of [Depth];
  int head, tail, count, loaded, frag_idx, retries, waited;
  bit awaiting;

  ftq_pkg::res_t expected_results [$];

  function automatic int fragments_for(int len);
    return (len + ftq_pkg::BytesPerFrag - 1) / ftq_pkg::BytesPerFrag;
  endfunction

  function automatic ftq_pkg::res_t make_result(logic [2:0] ev, logic [3:0] ty, int total,
                                                int idx, logic [47:0] pay, int rn);
    ftq_pkg::res_t r;
    r.event_res = ev;
    r.frame_type = ty;
    r.frame_total = total[5:0];
    r.frame_index = idx[5:0];
    r.frame_payload = pay;
    r.retry_number = rn[3:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void retire_head();
    head = (head + 1) % Depth;
    count--;
    frag_idx = 0;
    retries = 0;
    awaiting = 0;
    waited = 0;
  endfunction

  // Works out the results of one accepted command and queues them.
  function automatic void predict_command(logic [1:0] cmd, logic [3:0] ptype,
                                          logic [7:0] dbyte, logic lastb, logic [7:0] ack);
    ftq_pkg::res_t batch [$];
    int len, total;
    logic [47:0] pay;
    if (cmd == ftq_pkg::CmdLoad) begin
      if (loaded >= MaxLen || count >= Depth) begin
        loaded = BadLoad;
      end else begin
        store[tail * MaxLen + loaded] = dbyte;
        loaded++;
      end
      if (lastb) begin
        len = loaded;
        loaded = 0;
        if (len > MaxLen || len == 0 || count >= Depth) begin
          batch.push_back(make_result(ftq_pkg::EvRej, ptype, 0, 0, '0, 0));
        end else begin
          total = fragments_for(len);
          if (total > ftq_pkg::MaxFragmentsDef) begin
            batch.push_back(make_result(ftq_pkg::EvRej, ptype, total, 0, '0, 0));
          end else begin
            type_of[tail] = ptype;
            len_of[tail] = len;
            tail = (tail + 1) % Depth;
            count++;
            batch.push_back(make_result(ftq_pkg::EvEnq, ptype, total, 0, '0, 0));
          end
        end
      end
    end else if (cmd == ftq_pkg::CmdTick && count > 0) begin
      // Timeout check on the head comes before the fragment send.
      if (awaiting) begin
        if (waited < 16'hFFFF) waited++;
        if (waited >= timeout_ticks) begin
          if (retries < retry_limit) begin
            retries++;
            frag_idx = 0;
            awaiting = 0;
            waited = 0;
          end else begin
            batch.push_back(make_result(ftq_pkg::EvFail, type_of[head],
                                        fragments_for(len_of[head]), 0, '0, retries));
            retire_head();
          end
        end
      end
      if (count > 0 && !awaiting) begin
        len = len_of[head];
        total = fragments_for(len);
        pay = '0;
        for (int i = 0; i < ftq_pkg::BytesPerFrag; i++) begin
          pay = pay << 8;
          if (frag_idx * ftq_pkg::BytesPerFrag + i < len)
            pay[7:0] = store[head * MaxLen + frag_idx * ftq_pkg::BytesPerFrag + i];
        end
        batch.push_back(make_result(ftq_pkg::EvFrag, type_of[head], total, frag_idx, pay,
                                    retries));
        frag_idx++;
        if (frag_idx >= total) begin
          frag_idx = 0;
          awaiting = 1;
          waited = 0;
        end
      end
    end else if (cmd == ftq_pkg::CmdAck && count > 0 && ack == ok_code) begin
      batch.push_back(make_result(ftq_pkg::EvDeliv, type_of[head], fragments_for(len_of[head]),
                                  0, '0, retries));
      retire_head();
    end
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
      foreach (batch[k]) expected_results.push_back(batch[k]);
    end
  endfunction

  // Sample both channels at each rising edge.
  always @(posedge clk) begin
    ftq_pkg::res_t want;
    if (!rst_n) begin
      timeout_ticks = ftq_pkg::TimeoutRst;
      retry_limit = ftq_pkg::MaxRetriesRst;
      ok_code = ftq_pkg::AckOkRst;
      head = 0; tail = 0; count = 0; loaded = 0;
      frag_idx = 0; retries = 0; awaiting = 0; waited = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == ftq_pkg::RegTimeout) timeout_ticks = cfg_data;
        else if (cfg_index == ftq_pkg::RegRetries) retry_limit = cfg_data[3:0];
        else if (cfg_index == ftq_pkg::RegAckOk) ok_code = cfg_data[7:0];
      end
      if (in_valid && !in_stall)
        predict_command(in_command, in_packet_type, in_data_byte, in_last_byte, in_ack_code);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction, event %0d", out_event_res);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_event_res !== want.event_res) begin
            $error("event_res: expected %0d, got %0d", want.event_res, out_event_res);
            fail_count++;
          end
          if (out_frame_type !== want.frame_type) begin
            $error("frame_type: expected %0d, got %0d", want.frame_type, out_frame_type);
            fail_count++;
          end
          if (out_frame_total !== want.frame_total) begin
            $error("frame_total: expected %0d, got %0d", want.frame_total, out_frame_total);
            fail_count++;
          end
          if (out_frame_index !== want.frame_index) begin
            $error("frame_index: expected %0d, got %0d", want.frame_index, out_frame_index);
            fail_count++;
          end
          if (out_frame_payload !== want.frame_payload) begin
            $error("frame_payload: expected %h, got %h", want.frame_payload,
                   out_frame_payload);
            fail_count++;
          end
          if (out_retry_number !== want.retry_number) begin
            $error("retry_number: expected %0d, got %0d", want.retry_number,
                   out_retry_number);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            fail_count++;
          end
        end
      end
    end
    pending_results = expected_results.size();
  end

endmodule

@@ bench/fragmenting_tx_queue_with_ack_retry_core_test.sv @@
`timescale 1ns / 1ps

// Drives commands and configuration into the transmit queue and gives the verdict.
module fragmenting_tx_queue_with_ack_retry_core_test;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = '0;
  logic [3:0] in_packet_type = '0;
  logic [7:0] in_data_byte = '0;
  logic in_last_byte = 1'b0;
  logic [7:0] in_ack_code = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [3:0] out_frame_type;
  logic [5:0] out_frame_total;
  logic [5:0] out_frame_index;
  logic [47:0] out_frame_payload;
  logic [3:0] out_retry_number;
  logic out_last;
  int fail_count, pending_results, results_seen;

  int send_idle_pct = 16;
  int recv_idle_pct = 69;
  int sent_items = 0;
  logic [7:0] cur_ok = ftq_pkg::AckOkRst;

  always #1 clk = ~clk;

  fragmenting_tx_queue_with_ack_retry_core u_top (.*);

  fragmenting_tx_queue_with_ack_retry_core_checker u_check (.*);

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Sends one transaction, with an optional random gap first.
  task automatic send_cmd(logic [1:0] cmd, logic [3:0] ptype, logic [7:0] dbyte,
                          logic lastb, logic [7:0] ack);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_packet_type <= ptype;
    in_data_byte <= dbyte;
    in_last_byte <= lastb;
    in_ack_code <= ack;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic load_packet(int len, logic [3:0] ptype);
    for (int i = 0; i < len; i++)
      send_cmd(ftq_pkg::CmdLoad, 4'($urandom_range(15)), 8'($urandom_range(255)),
               i == len - 1, 8'($urandom));
    if (len == 0) send_cmd(ftq_pkg::CmdLoad, ptype, 8'($urandom_range(255)), 1'b1, 8'h00);
  endtask

  // Waits until all results are in and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One register write, with the write port then left idle before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ftq_pkg::RegAckOk) cur_ok = val[7:0];
  endtask

  // Random phase: whole packets, bursts of ticks, acks and some random commands.
  task automatic random_phase(int items);
    int stop;
    int len;
    stop = sent_items + items;
    while (sent_items < stop) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          len = ($urandom_range(7) == 0) ? int'($urandom_range(60))
                                         : int'($urandom_range(1, 14));
          load_packet(len, 4'($urandom_range(15)));
        end
        3, 4, 5, 6:
          repeat ($urandom_range(1, 6))
            send_cmd(ftq_pkg::CmdTick, 4'($urandom), 8'($urandom), 1'($urandom),
                     8'($urandom));
        7, 8:
          send_cmd(ftq_pkg::CmdAck, 4'($urandom), 8'($urandom), 1'($urandom),
                   ($urandom_range(2) != 0) ? cur_ok : 8'($urandom));
        default:
          send_cmd(2'($urandom_range(3)), 4'($urandom), 8'($urandom), 1'($urandom),
                   8'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short timeout so retries and failures come quickly.
    write_reg(ftq_pkg::RegTimeout, 16'd1);
    write_reg(ftq_pkg::RegRetries, 16'd1);
    write_reg(ftq_pkg::RegAckOk, 16'h00A5);
    send_cmd(ftq_pkg::CmdTick, 4'hF, 8'hFF, 1'b1, 8'hFF);       // tick on empty queue
    send_cmd(ftq_pkg::CmdAck, 4'h0, 8'h00, 1'b0, 8'hA5);        // ack on empty queue
    send_cmd(ftq_pkg::CmdUnused, 4'hF, 8'hFF, 1'b1, 8'hFF);     // unused command
    send_cmd(ftq_pkg::CmdLoad, 4'hF, 8'hFF, 1'b1, 8'h00);       // one-byte packet
    send_cmd(ftq_pkg::CmdLoad, 4'h0, 8'h00, 1'b1, 8'h00);
    load_packet(13, 4'h3);
    repeat (4) send_cmd(ftq_pkg::CmdTick, 4'h0, 8'h00, 1'b0, 8'h00);
    send_cmd(ftq_pkg::CmdAck, 4'h0, 8'h00, 1'b0, 8'h5A);        // wrong code
    send_cmd(ftq_pkg::CmdAck, 4'h0, 8'h00, 1'b0, 8'hA5);
    load_packet(40, 4'h7);                                       // oversized packet
    drain();

    // Queue full, fragment sends, an acknowledgement and the largest timeout.
    write_reg(ftq_pkg::RegTimeout, 16'hFFFF);
    write_reg(ftq_pkg::RegRetries, 16'd0);
    write_reg(ftq_pkg::RegAckOk, 16'h0000);
    repeat (5) load_packet(32, 4'h9);
    repeat (8) send_cmd(ftq_pkg::CmdTick, 4'h0, 8'h00, 1'b0, 8'h00);
    send_cmd(ftq_pkg::CmdAck, 4'h0, 8'h00, 1'b0, 8'h00);
    drain();

    // Random phases across register settings and idle profiles.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin send_idle_pct = 69; recv_idle_pct = 16; end
      if (phase == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      write_reg(ftq_pkg::RegTimeout, (phase == 5) ? 16'd65535 : 16'($urandom_range(1, 5)));
      write_reg(ftq_pkg::RegRetries, (phase == 1) ? 16'd15 : 16'($urandom_range(3)));
      write_reg(ftq_pkg::RegAckOk, (phase == 3) ? 16'h00FF : 16'($urandom_range(255)));
      random_phase(145);
      drain();
    end

    $display("Covered %0d commands and %0d result transactions across six register settings,",
             sent_items, results_seen);
    $display("including rejects, retries, failures and a full queue.");
    if (fail_count == 0)
      $display("fragmenting_tx_queue_with_ack_retry_core: match");
    else
      $display("fragmenting_tx_queue_with_ack_retry_core: mismatch");
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #3000000;
    $display("fragmenting_tx_queue_with_ack_retry_core: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ftq_pkg.sv
hw/rtl/ftq_front.sv
hw/rtl/ftq_back.sv
hw/rtl/fragmenting_tx_queue_with_ack_retry_core.sv
bench/fragmenting_tx_queue_with_ack_retry_core_checker.sv
bench/fragmenting_tx_queue_with_ack_retry_core_test.sv
